>>> hw/rtl/quadrature_encoder_position_top_defines.svh
// Assertion macros shared by the quadrature encoder position RTL.
`ifndef QUADRATURE_ENCODER_POSITION_TOP_DEFINES_SVH
`define QUADRATURE_ENCODER_POSITION_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and idle while rst_ni is low.
`define QEP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("qep: same-cycle check failed");

// Next-cycle implication, sampled on clk_i and idle while rst_ni is low.
`define QEP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("qep: next-cycle check failed");

`endif

>>> hw/rtl/qep_pkg.sv
// Types, constants and register map of the quadrature encoder position block.
package qep_pkg;

  // Width of the stored position and the near-edge window in detents.
  localparam int unsigned QEP_POS_BITS  = 16;
  localparam int unsigned QEP_NEAR_EDGE = 10;

  // Working width for position arithmetic: room for the wider of position
  // and limit, plus a carry bit so sums compare without wrapping.
  localparam int unsigned QEP_CALC_BITS = ((QEP_POS_BITS > 16) ? QEP_POS_BITS : 16) + 1;

  // Register map.
  localparam int unsigned QEP_NUM_REGS     = 5;
  localparam int unsigned QEP_ADDR_BITS    = $clog2(QEP_NUM_REGS * 4);
  localparam int unsigned QEP_REG_IDX_BITS = QEP_ADDR_BITS - 2;

  typedef enum logic [QEP_REG_IDX_BITS-1:0] {
    REG_MAX_POSITION   = 3'd0,
    REG_PAUSE_US       = 3'd1,
    REG_FAST_STEP      = 3'd2,
    REG_POWER_LIMIT_MW = 3'd3,
    REG_TEMP_LIMIT     = 3'd4
  } qep_reg_e;

  // Reset values of the configuration registers.
  localparam logic [15:0] QEP_RST_MAX_POSITION   = 16'd65535;
  localparam logic [31:0] QEP_RST_PAUSE_US       = 32'd25000;
  localparam logic [15:0] QEP_RST_FAST_STEP      = 16'd10;
  localparam logic [19:0] QEP_RST_POWER_LIMIT_MW = 20'hFFFFF;
  localparam logic [11:0] QEP_RST_TEMP_LIMIT     = 12'd1500;

  // Reset value of the previous pin pair: both pins high.
  localparam logic [1:0] QEP_RST_PREV_AB = 2'b11;

  // Quadrature transition table, indexed by {previous B A, current B A}.
  localparam logic signed [1:0] QEP_TRANS_TAB [16] = '{
    2'sd0, -2'sd1,  2'sd1,  2'sd0,
    2'sd1,  2'sd0,  2'sd0, -2'sd1,
   -2'sd1,  2'sd0,  2'sd0,  2'sd1,
    2'sd0,  2'sd1, -2'sd1,  2'sd0
  };

  // Configuration seen by the datapath.
  typedef struct packed {
    logic [15:0]        max_position;
    logic [31:0]        pause_us;
    logic [15:0]        fast_step;
    logic [19:0]        power_limit_mw;
    logic signed [11:0] temp_limit;
  } qep_cfg_t;

  // One input beat: a pin-change event.
  typedef struct packed {
    logic               pin_a;
    logic               pin_b;
    logic [31:0]        time_us;
    logic [19:0]        power_mw;
    logic signed [11:0] temperature;
  } qep_in_t;

  // One output beat.
  typedef struct packed {
    logic [15:0] position;
    logic        moved_up;
    logic        moved_down;
    logic        up_blocked;
  } qep_out_t;

endpackage

>>> hw/rtl/qep_regs.sv
// APB configuration register file of the quadrature encoder position block.
module qep_regs
  import qep_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [QEP_ADDR_BITS-1:0] paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  output qep_cfg_t                 cfg_o
);

  qep_cfg_t cfg_q;
  qep_reg_e reg_sel;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_sel = qep_reg_e'(paddr[QEP_ADDR_BITS-1:2]);
  assign wr_en   = psel && penable && pwrite && pready;
  assign cfg_o   = cfg_q;

  // Register writes in the access phase; unmapped addresses are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_position   <= QEP_RST_MAX_POSITION;
      cfg_q.pause_us       <= QEP_RST_PAUSE_US;
      cfg_q.fast_step      <= QEP_RST_FAST_STEP;
      cfg_q.power_limit_mw <= QEP_RST_POWER_LIMIT_MW;
      cfg_q.temp_limit     <= QEP_RST_TEMP_LIMIT;
    end else if (wr_en) begin
      case (reg_sel)
        REG_MAX_POSITION:   cfg_q.max_position   <= pwdata[15:0];
        REG_PAUSE_US:       cfg_q.pause_us       <= pwdata;
        REG_FAST_STEP:      cfg_q.fast_step      <= pwdata[15:0];
        REG_POWER_LIMIT_MW: cfg_q.power_limit_mw <= pwdata[19:0];
        REG_TEMP_LIMIT:     cfg_q.temp_limit     <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  // Read mux.
  always_comb begin
    case (reg_sel)
      REG_MAX_POSITION:   prdata = {16'd0, cfg_q.max_position};
      REG_PAUSE_US:       prdata = cfg_q.pause_us;
      REG_FAST_STEP:      prdata = {16'd0, cfg_q.fast_step};
      REG_POWER_LIMIT_MW: prdata = {12'd0, cfg_q.power_limit_mw};
      REG_TEMP_LIMIT:     prdata = {20'd0, cfg_q.temp_limit};
      default:            prdata = 32'd0;
    endcase
  end

endmodule

>>> hw/rtl/qep_core.sv
// Quadrature decode, detent timing and position update with its state.
module qep_core
  import qep_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  qep_cfg_t cfg_i,
  input  qep_in_t  beat_i,
  input  logic     advance_i,
  output qep_out_t result_o
);

  logic [1:0]               prev_ab_q;
  logic signed [3:0]        step_sum_q, step_sum_d;
  logic [QEP_POS_BITS-1:0]  pos_q, pos_d;
  logic [31:0]              last_up_q, last_up_d;
  logic [31:0]              last_down_q, last_down_d;

  logic [1:0]               cur_ab;
  logic signed [1:0]        delta;
  logic signed [3:0]        sum;
  logic                     up_det, down_det, up_allowed;
  logic [31:0]              up_elapsed, down_elapsed;
  logic                     up_fast, down_fast;
  logic [QEP_CALC_BITS-1:0] pos_w, maxp_w, near_w, up_step, down_step;
  logic [QEP_CALC_BITS-1:0] up_raw, up_clip, down_raw, down_clip;

  // Transition lookup and step accumulation.
  assign cur_ab   = {beat_i.pin_b, beat_i.pin_a};
  assign delta    = QEP_TRANS_TAB[{prev_ab_q, cur_ab}];
  assign sum      = step_sum_q + {{2{delta[1]}}, delta};
  assign up_det   = (sum > 4'sd3);
  assign down_det = (sum < -4'sd3);

  // Acceleration: same-direction detent inside the pause window, modulo 2^32.
  assign up_elapsed   = beat_i.time_us - last_up_q;
  assign down_elapsed = beat_i.time_us - last_down_q;
  assign up_fast      = (up_elapsed < cfg_i.pause_us);
  assign down_fast    = (down_elapsed < cfg_i.pause_us);

  assign up_allowed = (beat_i.power_mw < cfg_i.power_limit_mw) &&
                      (beat_i.temperature < cfg_i.temp_limit);

  // Position arithmetic in a width that cannot wrap.
  assign pos_w     = QEP_CALC_BITS'(pos_q);
  assign maxp_w    = QEP_CALC_BITS'(cfg_i.max_position);
  assign near_w    = QEP_CALC_BITS'(QEP_NEAR_EDGE);
  assign up_step   = up_fast   ? QEP_CALC_BITS'(cfg_i.fast_step) : QEP_CALC_BITS'(1);
  assign down_step = down_fast ? QEP_CALC_BITS'(cfg_i.fast_step) : QEP_CALC_BITS'(1);

  // Up: single steps near the limit, then clamp to the limit.
  always_comb begin
    if (pos_w + near_w > maxp_w) begin
      up_raw = (pos_w < maxp_w) ? pos_w + QEP_CALC_BITS'(1) : maxp_w;
    end else begin
      up_raw = pos_w + up_step;
    end
    up_clip = (up_raw >= maxp_w) ? maxp_w : up_raw;
  end

  // Down: single steps near zero, else saturating subtract; one snaps to zero.
  always_comb begin
    if (pos_w < near_w) begin
      down_raw = (pos_w > QEP_CALC_BITS'(1)) ? pos_w - QEP_CALC_BITS'(1) : '0;
    end else begin
      down_raw = (down_step >= pos_w) ? '0 : pos_w - down_step;
    end
    down_clip = (down_raw <= QEP_CALC_BITS'(1)) ? '0 : down_raw;
  end

  // Next state.
  always_comb begin
    step_sum_d  = sum;
    pos_d       = pos_q;
    last_up_d   = last_up_q;
    last_down_d = last_down_q;
    if (up_det) begin
      step_sum_d = '0;
      last_up_d  = beat_i.time_us;
      if (up_allowed) begin
        pos_d = up_clip[QEP_POS_BITS-1:0];
      end
    end else if (down_det) begin
      step_sum_d  = '0;
      last_down_d = beat_i.time_us;
      pos_d       = down_clip[QEP_POS_BITS-1:0];
    end
  end

  // Result of this event.
  always_comb begin
    result_o.position   = 16'(pos_d);
    result_o.moved_up   = up_det;
    result_o.moved_down = down_det;
    result_o.up_blocked = up_det && !up_allowed;
  end

  // State advances as the event leaves the input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_ab_q   <= QEP_RST_PREV_AB;
      step_sum_q  <= '0;
      pos_q       <= '0;
      last_up_q   <= '0;
      last_down_q <= '0;
    end else if (advance_i) begin
      prev_ab_q   <= cur_ab;
      step_sum_q  <= step_sum_d;
      pos_q       <= pos_d;
      last_up_q   <= last_up_d;
      last_down_q <= last_down_d;
    end
  end

endmodule

>>> hw/rtl/quadrature_encoder_position_top.sv
// Top level of the quadrature encoder position block: handshake, registers, datapath.
//
//  Channel  | Direction | Handshake              | Payload
//  ---------+-----------+------------------------+--------------------------------
//  input    | in        | in_valid_i / in_ready_o | in_data_i  (pins, time, power, temp)
//  output   | out       | out_valid_o/out_ready_i | out_data_o (position, detent flags)
//  config   | in        | APB psel/penable/pready | paddr, pwdata, prdata
//
// One event per clock is accepted and one result per clock is delivered
// while the output is not stalled. An accepted beat is held in the input
// register; the datapath computes its result and updates the position state
// as it moves into the output register.
// Reset restores the register defaults and clears the valid bits and datapath state at once.
// A stalled output holds its beat; the input register then holds one more
// beat before in_ready_o drops.
module quadrature_encoder_position_top
  import qep_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  qep_in_t                  in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output qep_out_t                 out_data_o,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [QEP_ADDR_BITS-1:0] paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

`include "quadrature_encoder_position_top_defines.svh"

  qep_cfg_t cfg;
  qep_in_t  in_q;
  logic     in_valid_q;
  qep_out_t out_q, result;
  logic     out_valid_q;
  logic     advance;

  qep_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  qep_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .beat_i    (in_q),
    .advance_i (advance),
    .result_o  (result)
  );

  // The input beat moves on whenever the output register is free or drains.
  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Valid bits of the two stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      out_q <= result;
    end
  end

  // Input stalls only behind a full, blocked output register.
  `QEP_ASSERT_IMPL(a_ready_only_stalls_on_output, !in_ready_o, out_valid_o && !out_ready_i)
  // A blocked increment is always an up detent.
  `QEP_ASSERT_IMPL(a_blocked_is_up, out_valid_o && out_data_o.up_blocked, out_data_o.moved_up)
  // An accepted up detent never leaves the position above the limit.
  `QEP_ASSERT_IMPL(a_up_within_limit,
                   out_valid_o && out_data_o.moved_up && !out_data_o.up_blocked,
                   out_data_o.position <= cfg.max_position)
  // A down detent never leaves the position at one.
  `QEP_ASSERT_NEXT(a_down_not_one, advance && result.moved_down, out_data_o.position != 16'd1)

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench of the quadrature encoder position block.
module tb_top;
  import qep_pkg::*;

  // Quadrature step value, indexed by {previous B A, current B A}.
  localparam int TURN_DELTA [16] = '{0, -1, 1, 0, 1, 0, 0, -1, -1, 0, 0, 1, 0, 1, -1, 0};
  // Next pin pair {B, A} for one step up or down.
  localparam logic [1:0] NEXT_UP [4] = '{2'd2, 2'd0, 2'd3, 2'd1};
  localparam logic [1:0] NEXT_DN [4] = '{2'd1, 2'd3, 2'd0, 2'd2};
  localparam int PHASE_ITEMS = 90;
  localparam int LONG_HOLD_CYCLES = 400;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  qep_in_t                  in_data = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  qep_out_t                 out_data;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [QEP_ADDR_BITS-1:0] paddr = '0;
  logic [31:0]              pwdata = '0;
  logic [31:0]              prdata;
  logic                     pready;

  quadrature_encoder_position_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // 2 ns clock.
  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // Shadow of the configuration registers.
  logic [15:0]        cfg_max   = QEP_RST_MAX_POSITION;
  logic [31:0]        cfg_pause = QEP_RST_PAUSE_US;
  logic [15:0]        cfg_fast  = QEP_RST_FAST_STEP;
  logic [19:0]        cfg_power = QEP_RST_POWER_LIMIT_MW;
  logic signed [11:0] cfg_temp  = QEP_RST_TEMP_LIMIT;

  // Tracked encoder state.
  logic [1:0]  last_ab      = QEP_RST_PREV_AB;
  int          turn_sum     = 0;
  logic [15:0] track_pos    = '0;
  logic [31:0] last_up_us   = '0;
  logic [31:0] last_down_us = '0;

  // Event generator state.
  logic [1:0]  gen_ab   = 2'd3;
  logic [31:0] gen_time = '0;

  qep_in_t  pending_events[$];
  qep_out_t expected_results[$];
  int       mismatch_cnt = 0;

  // Idling controls, set per phase by the stimulus process.
  bit send_idle_en = 1'b1;
  bit take_idle_en = 1'b1;
  bit long_hold_req = 1'b0;
  bit long_hold_done = 1'b0;
  int send_gap = 0;
  int take_gap = 0;
  int hold_left = 0;

  // Applies one pin-change event to the tracked state and returns its result.
  function automatic qep_out_t track_position(qep_in_t ev);
    logic [1:0]  cur_ab;
    logic [31:0] elapsed;
    int unsigned stride;
    int unsigned pos;
    int unsigned limit;
    qep_out_t    res;
    cur_ab = {ev.pin_b, ev.pin_a};
    turn_sum += TURN_DELTA[{last_ab, cur_ab}];
    last_ab = cur_ab;
    pos = track_pos;
    limit = cfg_max;
    res = '0;
    if (turn_sum > 3) begin
      res.moved_up = 1'b1;
      turn_sum = 0;
      elapsed = ev.time_us - last_up_us;
      stride = (elapsed < cfg_pause) ? int'(cfg_fast) : 1;
      last_up_us = ev.time_us;
      if (ev.power_mw < cfg_power && $signed(ev.temperature) < $signed(cfg_temp)) begin
        // Near the top only single steps are taken.
        if (pos + QEP_NEAR_EDGE > limit) begin
          pos = (pos < limit) ? pos + 1 : limit;
        end else begin
          pos = pos + stride;
        end
        if (pos >= limit) begin
          pos = limit;
        end
      end else begin
        res.up_blocked = 1'b1;
      end
    end else if (turn_sum < -3) begin
      res.moved_down = 1'b1;
      turn_sum = 0;
      elapsed = ev.time_us - last_down_us;
      stride = (elapsed < cfg_pause) ? int'(cfg_fast) : 1;
      last_down_us = ev.time_us;
      if (pos < QEP_NEAR_EDGE) begin
        pos = (pos > 1) ? pos - 1 : 0;
      end else begin
        pos = (stride >= pos) ? 0 : pos - stride;
      end
      if (pos <= 1) begin
        pos = 0;
      end
    end
    track_pos = pos[15:0];
    res.position = track_pos;
    return res;
  endfunction

  // Power reading, mostly below the limit so up detents move.
  function automatic logic [19:0] pick_power();
    case ($urandom_range(0, 9))
      0: return 20'($urandom);
      1: return cfg_power;
      default: return (cfg_power == 0) ? 20'd0 : 20'($urandom_range(0, cfg_power - 1));
    endcase
  endfunction

  // Temperature reading in the legal range, mostly below the limit.
  function automatic logic signed [11:0] pick_temp();
    int lo;
    int hi;
    int v;
    lo = -550;
    hi = int'($signed(cfg_temp)) - 1;
    case ($urandom_range(0, 9))
      0: v = int'($urandom_range(0, 2050)) - 550;
      1: v = int'($signed(cfg_temp));
      default: v = (hi < lo) ? lo : lo + int'($urandom_range(0, hi - lo));
    endcase
    return v[11:0];
  endfunction

  // Time between events: short enough to accelerate, just over a quarter of the pause window, or anything.
  function automatic logic [31:0] pick_gap(int mode);
    logic [31:0] span;
    case (mode)
      1: return (cfg_pause >> 2) + $urandom_range(1, 1000);
      2: return $urandom;
      default: begin
        span = cfg_pause >> 3;
        if (span > 2000) begin
          span = 2000;
        end
        return $urandom_range(0, span);
      end
    endcase
  endfunction

  task automatic flag_error(string what);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) begin
      $display("%0t: %s", $time, what);
    end
  endtask

  task automatic queue_event(logic [19:0] pw, logic signed [11:0] tp);
    qep_in_t ev;
    ev.pin_a       = gen_ab[0];
    ev.pin_b       = gen_ab[1];
    ev.time_us     = gen_time;
    ev.power_mw    = pw;
    ev.temperature = tp;
    pending_events.push_back(ev);
  endtask

  // One quadrature step in the given direction with random readings.
  task automatic advance(bit up, int mode);
    gen_ab = up ? NEXT_UP[gen_ab] : NEXT_DN[gen_ab];
    gen_time += pick_gap(mode);
    queue_event(pick_power(), pick_temp());
  endtask

  // Four steps that make one detent, with fixed spacing and readings.
  task automatic turn_detent(bit up, logic [31:0] dt, logic [19:0] pw,
                             logic signed [11:0] tp);
    repeat (4) begin
      gen_ab = up ? NEXT_UP[gen_ab] : NEXT_DN[gen_ab];
      gen_time += dt;
      queue_event(pw, tp);
    end
  endtask

  // Mostly clean turns with random content, some reversals and some noise.
  task automatic fill_random(int want);
    int made;
    int pick;
    int mode;
    bit up;
    made = 0;
    while (made < want) begin
      pick = $urandom_range(0, 9);
      mode = $urandom_range(0, 3);
      up = $urandom_range(0, 1);
      if (mode == 3 && $urandom_range(0, 1) == 1) begin
        gen_time = 32'hFFFF_FFFF - $urandom_range(0, 3000);
      end
      if (pick < 7) begin
        repeat (4 * $urandom_range(1, 3)) begin
          advance(up, mode);
          made++;
        end
      end else if (pick == 7) begin
        repeat ($urandom_range(1, 3)) begin
          advance(up, mode);
          made++;
        end
        repeat ($urandom_range(1, 3)) begin
          advance(!up, mode);
          made++;
        end
      end else begin
        gen_ab = 2'($urandom);
        gen_time += $urandom;
        queue_event(pick_power(), pick_temp());
        made++;
      end
    end
  endtask

  task automatic apb_write(qep_reg_e which, logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {which, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic program_limits(logic [15:0] maxp, logic [31:0] pause, logic [15:0] fast,
                                logic [19:0] power, logic signed [11:0] temp);
    apb_write(REG_MAX_POSITION, 32'(maxp));
    apb_write(REG_PAUSE_US, pause);
    apb_write(REG_FAST_STEP, 32'(fast));
    apb_write(REG_POWER_LIMIT_MW, 32'(power));
    apb_write(REG_TEMP_LIMIT, {{20{temp[11]}}, temp});
    cfg_max   = maxp;
    cfg_pause = pause;
    cfg_fast  = fast;
    cfg_power = power;
    cfg_temp  = temp;
  endtask

  // Sampled on the falling edge so the driver's updates from the rising edge have settled.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_events.size() != 0 || in_valid || expected_results.size() != 0);
  endtask

  // Input driver: offers queued events, predicts each accepted beat.
  always @(posedge clk_i or negedge rst_ni) begin : drive_events
    logic    offer;
    qep_in_t beat;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      offer = in_valid;
      if (in_valid && in_ready) begin
        expected_results.push_back(track_position(in_data));
        offer = 1'b0;
      end
      if (!offer) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_events.size() > 0) begin
          beat = pending_events.pop_front();
          in_data <= beat;
          offer = 1'b1;
          if (send_idle_en && $urandom_range(0, 7) == 0) begin
            send_gap = $urandom_range(1, 17);
          end
        end
      end
      in_valid <= offer;
    end
  end

  // Output monitor: checks each accepted beat and paces out_ready.
  always @(posedge clk_i or negedge rst_ni) begin : watch_results
    qep_out_t want;
    logic     rdy;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          flag_error($sformatf("unexpected result: pos %0d up %0b down %0b blocked %0b",
                               out_data.position, out_data.moved_up, out_data.moved_down,
                               out_data.up_blocked));
        end else begin
          want = expected_results.pop_front();
          if (out_data.position !== want.position || out_data.moved_up !== want.moved_up ||
              out_data.moved_down !== want.moved_down ||
              out_data.up_blocked !== want.up_blocked) begin
            flag_error($sformatf({"mismatch: expected pos %0d up %0b down %0b blocked %0b,",
                                  " got pos %0d up %0b down %0b blocked %0b"},
                                 want.position, want.moved_up, want.moved_down,
                                 want.up_blocked, out_data.position, out_data.moved_up,
                                 out_data.moved_down, out_data.up_blocked));
          end
        end
      end
      // A single long hold lets the block fill up and stall its input.
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (long_hold_req && !long_hold_done) begin
        hold_left = LONG_HOLD_CYCLES;
        long_hold_done = 1'b1;
        rdy = 1'b0;
      end else if (take_gap > 0) begin
        take_gap--;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
        if (take_idle_en && $urandom_range(0, 7) == 0) begin
          take_gap = $urandom_range(1, 17);
        end
      end
      out_ready <= rdy;
    end
  end

  // Stimulus: directed events at reset settings, then random phases.
  initial begin : run_stimulus
    int ph;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Field extremes with no motion.
    gen_ab = 2'd3;
    gen_time = 32'hFFFF_FFFF;
    queue_event(20'hF_FFFF, 12'sd1500);
    gen_time = '0;
    queue_event(20'd0, -12'sd550);
    // Accelerated up detent, then blocked at the power and temperature limits.
    turn_detent(1'b1, 32'd100, 20'd0, -12'sd550);
    turn_detent(1'b1, 32'd100, 20'hF_FFFF, 12'sd0);
    turn_detent(1'b1, 32'd100, 20'd0, 12'sd1500);
    // Down detents across the timestamp wrap, then a slow one at zero.
    gen_time = 32'hFFFF_FFF0;
    turn_detent(1'b0, 32'd8, 20'd777, 12'sd20);
    turn_detent(1'b0, 32'd30000, 20'd777, 12'sd20);
    wait_drained();

    for (ph = 1; ph <= 7; ph++) begin
      case (ph)
        1: program_limits(16'd40, 32'd1000, 16'd3, 20'd500000, 12'sd300);
        2: program_limits(16'd0, 32'd0, 16'd1, 20'd0, -12'sd550);
        3: program_limits(16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 20'hF_FFFF, 12'sd1500);
        // A zero fast step leaves accelerated detents to the edge rules.
        4: program_limits(16'd300, 32'd5000, 16'd0, 20'hF_FFFF, 12'sd1500);
        // Limit lowered under the current position.
        5: program_limits(16'($urandom_range(0, 20)), $urandom,
                          16'($urandom_range(1, 65535)), 20'($urandom), pick_temp());
        default: program_limits(16'($urandom_range(0, 3000)), $urandom_range(0, 100000),
                                16'($urandom_range(1, 200)), 20'($urandom), pick_temp());
      endcase
      if (ph == 5 || ph == 6) begin
        // Keep the random temperature limit inside the legal range.
        if ($signed(cfg_temp) < -550 || $signed(cfg_temp) > 1500) begin
          program_limits(cfg_max, cfg_pause, cfg_fast, cfg_power, 12'sd0);
        end
      end
      if (ph == 3) begin
        send_idle_en = 1'b0;
        take_idle_en = 1'b1;
        long_hold_req = 1'b1;
      end else if (ph == 7) begin
        send_idle_en = 1'b0;
        take_idle_en = 1'b0;
      end else begin
        send_idle_en = ($urandom_range(0, 3) != 0);
        take_idle_en = ($urandom_range(0, 3) != 0);
      end
      fill_random(PHASE_ITEMS);
      wait_drained();
    end

    repeat (10) @(posedge clk_i);
    if (mismatch_cnt == 0 && expected_results.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  // Watchdog.
  initial begin : watchdog
    #2_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/qep_pkg.sv
hw/rtl/qep_regs.sv
hw/rtl/qep_core.sv
hw/rtl/quadrature_encoder_position_top.sv
tb/sv/tb_top.sv
